// ===== design/ppsh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsh_pkg
// Shared types and constants of the point projection and shading pipeline.
// ----------------------------------------------------------------------------
package ppsh_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_COS_AZ = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_AZ = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS_PO = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_PO = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Z = 4'd7;

  // Register reset values
  localparam logic signed [15:0] COS_RST   = 16'sd16384;
  localparam logic signed [15:0] SIN_RST   = 16'sd0;
  localparam logic [15:0]        SCALE_RST = 16'd256;
  localparam logic [8:0]         GRID_RST  = 9'd64;
  localparam logic [14:0]        CAM_RST   = 15'd1638;

  // Camera offset: floor(x / 10) as (x * CAM_MUL) >> CAM_SHIFT, exact for 17-bit x
  localparam logic [19:0] CAM_MUL   = 20'd838861;
  localparam int          CAM_SHIFT = 23;

  // Divider and square root sizes
  localparam int QUO_W    = 18;
  localparam int DEN_W    = 37;
  localparam int REM_W    = DEN_W + QUO_W;
  localparam int SQ_IN_W  = 36;
  localparam int SQ_OUT_W = SQ_IN_W / 2;
  localparam int SQ_REM_W = SQ_OUT_W + 3;
  localparam int NUM_ITER = QUO_W;

  // Shading bases, Q8.8
  localparam logic [15:0] RED_BASE   = 16'd12800;
  localparam logic [15:0] GREEN_BASE = 16'd15360;
  localparam logic [15:0] BLUE_BASE  = 16'd19200;

  typedef struct packed {
    logic signed [15:0] cos_az;
    logic signed [15:0] sin_az;
    logic signed [15:0] cos_po;
    logic signed [15:0] sin_po;
    logic [15:0]        scale;
    logic [8:0]         grid_x;
    logic [8:0]         grid_y;
    logic [8:0]         grid_z;
    logic [14:0]        cam_x;
    logic [14:0]        cam_y;
    logic [14:0]        cam_z;
    logic [8:0]         max_side;
  } cfg_t;

  typedef struct packed {
    logic                vld;
    logic                last;
    logic                skip;
    logic                neg_x;
    logic                neg_y;
    logic                ovf_x;
    logic                ovf_y;
    logic [DEN_W-1:0]    den;
    logic [REM_W-1:0]    rem_x;
    logic [REM_W-1:0]    rem_y;
    logic [QUO_W-1:0]    quo_x;
    logic [QUO_W-1:0]    quo_y;
    logic [SQ_IN_W-1:0]  sv;
    logic [SQ_IN_W-1:0]  vv;
    logic [SQ_REM_W-1:0] srem;
    logic [SQ_REM_W-1:0] vrem;
    logic [SQ_OUT_W-1:0] sroot;
    logic [SQ_OUT_W-1:0] vroot;
  } iter_t;

endpackage

// ===== design/point_project_and_shade_core.sv =====
`timescale 1ns / 1ps
// Pipeline: 8 front stages, 18 divide and square root steps, 1 output stage.
// Throughput: one transaction per cycle, every step having a stage of its own;
//   the whole pipeline holds while a finished result waits on a stall.
// Reset: asynchronous, active low; clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
// point_project_and_shade_core
// Perspective point projection with distance and speed based shading.
// ----------------------------------------------------------------------------
module point_project_and_shade_core import ppsh_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [15:0]          pos_x_i,
  input  logic [15:0]          pos_y_i,
  input  logic [15:0]          pos_z_i,
  input  logic signed [15:0]   vel_x_i,
  input  logic signed [15:0]   vel_y_i,
  input  logic signed [15:0]   vel_z_i,
  input  logic                 last_point_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   screen_x_o,
  output logic signed [15:0]   screen_y_o,
  output logic [7:0]           red_o,
  output logic [7:0]           green_o,
  output logic [7:0]           blue_o,
  output logic                 skipped_o,
  output logic                 last_out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  cfg_t        cfg;
  logic        en;
  logic [14:0] cam_x_q, cam_y_q, cam_z_q;
  logic signed [15:0] cos_az_q, sin_az_q, cos_po_q, sin_po_q;
  logic [15:0] scale_q;
  logic [8:0]  grid_x_q, grid_y_q, grid_z_q, max_side;

  assign cfg_ready_o = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_az_q <= COS_RST;
      sin_az_q <= SIN_RST;
      cos_po_q <= COS_RST;
      sin_po_q <= SIN_RST;
      scale_q  <= SCALE_RST;
      grid_x_q <= GRID_RST;
      grid_y_q <= GRID_RST;
      grid_z_q <= GRID_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_COS_AZ: cos_az_q <= cfg_data_i;
        REG_SIN_AZ: sin_az_q <= cfg_data_i;
        REG_COS_PO: cos_po_q <= cfg_data_i;
        REG_SIN_PO: sin_po_q <= cfg_data_i;
        REG_SCALE:  scale_q  <= cfg_data_i;
        REG_GRID_X: grid_x_q <= cfg_data_i[8:0];
        REG_GRID_Y: grid_y_q <= cfg_data_i[8:0];
        REG_GRID_Z: grid_z_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // camera offset per axis: (grid*256 + 5) / 10
  function automatic logic [14:0] cam_of(input logic [8:0] g);
    logic [36:0] p;
    p = 37'({g, 8'b0} + 17'd5) * 37'(CAM_MUL);
    return p[CAM_SHIFT +: 15];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= CAM_RST;
      cam_y_q <= CAM_RST;
      cam_z_q <= CAM_RST;
    end else begin
      cam_x_q <= cam_of(grid_x_q);
      cam_y_q <= cam_of(grid_y_q);
      cam_z_q <= cam_of(grid_z_q);
    end
  end

  // largest grid side, zero taken as one
  always_comb begin
    max_side = grid_x_q;
    if (grid_y_q > max_side) max_side = grid_y_q;
    if (grid_z_q > max_side) max_side = grid_z_q;
    if (max_side == 9'd0) max_side = 9'd1;
  end

  always_comb begin
    cfg.cos_az   = cos_az_q;
    cfg.sin_az   = sin_az_q;
    cfg.cos_po   = cos_po_q;
    cfg.sin_po   = sin_po_q;
    cfg.scale    = scale_q;
    cfg.grid_x   = grid_x_q;
    cfg.grid_y   = grid_y_q;
    cfg.grid_z   = grid_z_q;
    cfg.cam_x    = cam_x_q;
    cfg.cam_y    = cam_y_q;
    cfg.cam_z    = cam_z_q;
    cfg.max_side = max_side;
  end

  // hold every stage while a finished result waits
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = out_valid_o && out_stall_i;

  iter_t chain [NUM_ITER+1];

  ppsh_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .in_valid_i   (in_valid_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .vel_x_i      (vel_x_i),
    .vel_y_i      (vel_y_i),
    .vel_z_i      (vel_z_i),
    .last_point_i (last_point_i),
    .cfg_i        (cfg),
    .iter_o       (chain[0])
  );

  for (genvar s = 0; s < NUM_ITER; s++) begin : g_iter
    ppsh_iter_stage #(
      .Step (s)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .iter_i (chain[s]),
      .iter_o (chain[s+1])
    );
  end

  ppsh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .iter_i      (chain[NUM_ITER]),
    .out_valid_o (out_valid_o),
    .screen_x_o  (screen_x_o),
    .screen_y_o  (screen_y_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .skipped_o   (skipped_o),
    .last_out_o  (last_out_o)
  );

endmodule

// ===== design/ppsh_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsh_front
// Centering, two rotations, perspective products and divider setup (8 stages).
// ----------------------------------------------------------------------------
module ppsh_front import ppsh_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               in_valid_i,
  input  logic [15:0]        pos_x_i,
  input  logic [15:0]        pos_y_i,
  input  logic [15:0]        pos_z_i,
  input  logic signed [15:0] vel_x_i,
  input  logic signed [15:0] vel_y_i,
  input  logic signed [15:0] vel_z_i,
  input  logic               last_point_i,
  input  cfg_t               cfg_i,
  output iter_t              iter_o
);

  logic signed [15:0] ca, sa, cp, sp;
  logic signed [16:0] sc;
  logic signed [9:0]  ms;

  assign ca = cfg_i.cos_az;
  assign sa = cfg_i.sin_az;
  assign cp = cfg_i.cos_po;
  assign sp = cfg_i.sin_po;
  assign sc = $signed({1'b0, cfg_i.scale});
  assign ms = $signed({1'b0, cfg_i.max_side});

  logic [6:0] vld_q, last_q;

  // stage 1
  logic signed [17:0] i1_q, j1_q, k1_q;
  logic signed [15:0] vx1_q, vy1_q, vz1_q;
  // stage 2
  logic signed [33:0] pic2_q, pks2_q, pis2_q, pkc2_q;
  logic signed [18:0] dx2_q, dy2_q, dz2_q;
  logic signed [31:0] vxx2_q, vyy2_q, vzz2_q;
  logic signed [17:0] nj2_q;
  // stage 3
  logic signed [20:0] iy3_q, ky3_q;
  logic [35:0]        dxx3_q, dyy3_q, dzz3_q, vsum3_q;
  logic signed [17:0] nj3_q;
  // stage 4
  logic [35:0]        ssum4_q, vsum4_q;
  logic signed [37:0] pjc4_q, pkys4_q, pjs4_q, pkyc4_q;
  logic signed [20:0] iy4_q;
  // stage 5
  logic signed [24:0] jyz5_q;
  logic signed [25:0] kyz5_q;
  logic signed [20:0] iy5_q;
  logic [35:0]        ssum5_q, vsum5_q;
  // stage 6
  logic signed [37:0] nx6_q;
  logic signed [41:0] ny6_q;
  logic signed [35:0] den6_q;
  logic               skip6_q;
  logic [35:0]        ssum6_q, vsum6_q;
  // stage 7
  logic               negx7_q, negy7_q, skip7_q;
  logic [37:0]        ux7_q;
  logic [41:0]        uy7_q;
  logic [35:0]        ud7_q;
  logic [35:0]        ssum7_q, vsum7_q;
  // stage 8
  iter_t              iter_q, iter_d;

  // rounded rotation sums and squares
  logic signed [34:0] sum_iy, sum_ky;
  logic signed [38:0] sum_j, sum_k;
  logic signed [37:0] dxx_c, dyy_c, dzz_c;

  always_comb begin
    sum_iy = pic2_q - pks2_q + 35'sd8192;
    sum_ky = pis2_q + pkc2_q + 35'sd8192;
    sum_j  = pjc4_q - pkys4_q + 39'sd8192;
    sum_k  = pjs4_q + pkyc4_q + 39'sd8192;
    dxx_c  = dx2_q * dx2_q;
    dyy_c  = dy2_q * dy2_q;
    dzz_c  = dz2_q * dz2_q;
  end

  // build the divider and square root seed
  always_comb begin
    logic [REM_W-1:0] nx, ny, dsh;
    logic [DEN_W-1:0] d;
    d     = {ud7_q, 1'b0};
    nx    = REM_W'({ux7_q, 7'b0}) + REM_W'(ud7_q);
    ny    = REM_W'({uy7_q, 7'b0}) + REM_W'(ud7_q);
    dsh   = {d, {QUO_W{1'b0}}};
    iter_d       = '0;
    iter_d.vld   = vld_q[6];
    iter_d.last  = last_q[6];
    iter_d.skip  = skip7_q;
    iter_d.neg_x = negx7_q;
    iter_d.neg_y = negy7_q;
    iter_d.ovf_x = (dsh <= nx);
    iter_d.ovf_y = (dsh <= ny);
    iter_d.den   = d;
    iter_d.rem_x = nx;
    iter_d.rem_y = ny;
    iter_d.sv    = ssum7_q;
    iter_d.vv    = vsum7_q;
  end

  // advance the valid flags and the stage 8 register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      iter_q.vld <= 1'b0;
    end else if (en_i) begin
      vld_q  <= {vld_q[5:0], in_valid_i};
      iter_q <= iter_d;
    end
  end

  // advance the datapath
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      last_q  <= {last_q[5:0], last_point_i};
      // center on the grid
      i1_q    <= $signed({2'b0, pos_x_i}) - $signed({2'b0, cfg_i.grid_x[8:1], 8'b0});
      j1_q    <= $signed({2'b0, pos_y_i}) - $signed({2'b0, cfg_i.grid_y[8:1], 8'b0});
      k1_q    <= $signed({2'b0, pos_z_i}) - $signed({2'b0, cfg_i.grid_z[8:1], 8'b0});
      vx1_q   <= vel_x_i;
      vy1_q   <= vel_y_i;
      vz1_q   <= vel_z_i;
      // azimuth products, camera offsets, speed squares
      pic2_q  <= i1_q * ca;
      pks2_q  <= k1_q * sa;
      pis2_q  <= i1_q * sa;
      pkc2_q  <= k1_q * ca;
      dx2_q   <= -($signed({4'b0, cfg_i.cam_x}) + i1_q);
      dy2_q   <= -($signed({4'b0, cfg_i.cam_y}) + j1_q);
      dz2_q   <= -($signed({4'b0, cfg_i.cam_z}) + k1_q);
      vxx2_q  <= vx1_q * vx1_q;
      vyy2_q  <= vy1_q * vy1_q;
      vzz2_q  <= vz1_q * vz1_q;
      nj2_q   <= -j1_q;
      // azimuth rounding, distance squares
      iy3_q   <= sum_iy[34:14];
      ky3_q   <= sum_ky[34:14];
      dxx3_q  <= dxx_c[35:0];
      dyy3_q  <= dyy_c[35:0];
      dzz3_q  <= dzz_c[35:0];
      vsum3_q <= {4'b0, vxx2_q} + {4'b0, vyy2_q} + {4'b0, vzz2_q};
      nj3_q   <= nj2_q;
      // polar products
      ssum4_q <= dxx3_q + dyy3_q + dzz3_q;
      vsum4_q <= vsum3_q;
      pjc4_q  <= nj3_q * cp;
      pkys4_q <= ky3_q * sp;
      pjs4_q  <= nj3_q * sp;
      pkyc4_q <= ky3_q * cp;
      iy4_q   <= iy3_q;
      // polar rounding, add grid depth
      jyz5_q  <= sum_j[38:14];
      kyz5_q  <= $signed(sum_k[38:14]) + $signed({1'b0, cfg_i.grid_z, 8'b0});
      iy5_q   <= iy4_q;
      ssum5_q <= ssum4_q;
      vsum5_q <= vsum4_q;
      // scale numerators, form denominator
      nx6_q   <= iy5_q * sc;
      ny6_q   <= jyz5_q * sc;
      den6_q  <= kyz5_q * ms;
      skip6_q <= (kyz5_q == 26'sd0);
      ssum6_q <= ssum5_q;
      vsum6_q <= vsum5_q;
      // split sign and magnitude
      negx7_q <= nx6_q[37] ^ den6_q[35];
      negy7_q <= ny6_q[41] ^ den6_q[35];
      ux7_q   <= nx6_q[37] ? 38'(-nx6_q) : 38'(nx6_q);
      uy7_q   <= ny6_q[41] ? 42'(-ny6_q) : 42'(ny6_q);
      ud7_q   <= den6_q[35] ? 36'(-den6_q) : 36'(den6_q);
      skip7_q <= skip6_q;
      ssum7_q <= ssum6_q;
      vsum7_q <= vsum6_q;
    end
  end

  assign iter_o = iter_q;

endmodule

// ===== design/ppsh_iter_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsh_iter_stage
// One registered step of both quotients and both square roots.
// ----------------------------------------------------------------------------
module ppsh_iter_stage import ppsh_pkg::*; #(
  parameter int Step = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  iter_t iter_i,
  output iter_t iter_o
);

  localparam int Shift = QUO_W - 1 - Step;

  iter_t iter_q, iter_d;

  always_comb begin
    logic [REM_W-1:0]    dsh;
    logic [SQ_REM_W-1:0] sr, vr, st, vt;
    iter_d = iter_i;
    // restoring division bit
    dsh = REM_W'(iter_i.den) << Shift;
    if (iter_i.rem_x >= dsh) begin
      iter_d.rem_x = iter_i.rem_x - dsh;
      iter_d.quo_x = {iter_i.quo_x[QUO_W-2:0], 1'b1};
    end else begin
      iter_d.quo_x = {iter_i.quo_x[QUO_W-2:0], 1'b0};
    end
    if (iter_i.rem_y >= dsh) begin
      iter_d.rem_y = iter_i.rem_y - dsh;
      iter_d.quo_y = {iter_i.quo_y[QUO_W-2:0], 1'b1};
    end else begin
      iter_d.quo_y = {iter_i.quo_y[QUO_W-2:0], 1'b0};
    end
    // square root digit, distance
    sr = {iter_i.srem[SQ_REM_W-3:0], iter_i.sv[SQ_IN_W-1 -: 2]};
    st = SQ_REM_W'({iter_i.sroot, 2'b01});
    if (sr >= st) begin
      iter_d.srem  = sr - st;
      iter_d.sroot = {iter_i.sroot[SQ_OUT_W-2:0], 1'b1};
    end else begin
      iter_d.srem  = sr;
      iter_d.sroot = {iter_i.sroot[SQ_OUT_W-2:0], 1'b0};
    end
    iter_d.sv = {iter_i.sv[SQ_IN_W-3:0], 2'b00};
    // square root digit, speed
    vr = {iter_i.vrem[SQ_REM_W-3:0], iter_i.vv[SQ_IN_W-1 -: 2]};
    vt = SQ_REM_W'({iter_i.vroot, 2'b01});
    if (vr >= vt) begin
      iter_d.vrem  = vr - vt;
      iter_d.vroot = {iter_i.vroot[SQ_OUT_W-2:0], 1'b1};
    end else begin
      iter_d.vrem  = vr;
      iter_d.vroot = {iter_i.vroot[SQ_OUT_W-2:0], 1'b0};
    end
    iter_d.vv = {iter_i.vv[SQ_IN_W-3:0], 2'b00};
  end

  // hold on stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q.vld <= 1'b0;
    end else if (en_i) begin
      iter_q <= iter_d;
    end
  end

  assign iter_o = iter_q;

endmodule

// ===== design/ppsh_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsh_back
// Saturates screen coordinates, shades the color channels (all zero for a skipped point), output register.
// ----------------------------------------------------------------------------
module ppsh_back import ppsh_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  iter_t              iter_i,
  output logic               out_valid_o,
  output logic signed [15:0] screen_x_o,
  output logic signed [15:0] screen_y_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic               skipped_o,
  output logic               last_out_o
);

  function automatic logic [15:0] sat(input logic [QUO_W-1:0] q, input logic ovf,
                                      input logic neg);
    logic [15:0] r;
    if (neg) begin
      if (ovf || q > QUO_W'(32768)) r = 16'h8000;
      else r = 16'(~q + 1'b1);
    end else begin
      if (ovf || q > QUO_W'(32767)) r = 16'h7FFF;
      else r = q[15:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] shade(input logic [15:0] base,
                                       input logic [SQ_OUT_W-1:0] gap,
                                       input logic [SQ_OUT_W-1:0] speed);
    logic signed [20:0] a;
    logic signed [29:0] t;
    logic [29:0]        v;
    logic [12:0]        y;
    logic [25:0]        p;
    logic [7:0]         r;
    a = $signed({5'b0, base}) - $signed({3'b0, gap}) + $signed({3'b0, speed});
    t = (30'(a) <<< 8) - 30'(a);
    if (t <= 30'sd0) begin
      r = 8'd0;
    end else begin
      v = 30'(t) + 30'd6400;
      if (v >= 30'd3276800) begin
        r = 8'd255;
      end else begin
        // divide by 12800: shift by 512, then multiply by reciprocal of 25
        y = v[21:9];
        p = 26'(y) * 26'd5243;
        r = p[24:17];
      end
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en_i) begin
      out_valid_o <= iter_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      last_out_o <= iter_i.last;
      skipped_o  <= iter_i.skip;
      if (iter_i.skip) begin
        screen_x_o <= '0;
        screen_y_o <= '0;
        red_o      <= '0;
        green_o    <= '0;
        blue_o     <= '0;
      end else begin
        screen_x_o <= sat(iter_i.quo_x, iter_i.ovf_x, iter_i.neg_x);
        screen_y_o <= sat(iter_i.quo_y, iter_i.ovf_y, iter_i.neg_y);
        red_o      <= shade(RED_BASE, iter_i.sroot, iter_i.vroot);
        green_o    <= shade(GREEN_BASE, iter_i.sroot, '0);
        blue_o     <= shade(BLUE_BASE, iter_i.sroot, '0);
      end
    end
  end

endmodule

// ===== verif/point_project_and_shade_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_project_and_shade_core_test
// Self-checking bench for the projection and shading core. A short table of
// directed points runs first, then random points under several register
// settings, with random idling on both channels. Every result is compared,
// field by field, with a model of the projection and shading math.
// ----------------------------------------------------------------------------
module point_project_and_shade_core_test;
  import ppsh_pkg::*;

  localparam int LATENCY     = 27;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] pz;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] vz;
    logic        last;
  } point_t;

  typedef struct packed {
    logic [15:0] sx;
    logic [15:0] sy;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        skip;
    logic        last;
  } pixel_t;

  typedef struct packed {
    logic          fixed;
    point_t        pt;
    pixel_t        px;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [15:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic last_point_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [15:0] screen_x_o, screen_y_o;
  logic [7:0] red_o, green_o, blue_o;
  logic skipped_o, last_out_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  point_project_and_shade_core dut (.*);

  // Model copy of the configuration registers
  logic [15:0] shadow_reg [8];

  pixel_t pixel_queue [$];
  int     errors = 0;
  int     cycles = 0;
  int     send_idle = 26;
  int     recv_idle = 50;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic longint fshift14(longint v);
    if (v >= 0) return v >>> 14;
    return -(((-v) - 1) >>> 14) - 1;
  endfunction

  function automatic longint root(longint v);
    longint res, bit_v;
    res = 0;
    bit_v = longint'(1) << 62;
    while (bit_v > v) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >>> 1) + bit_v;
      end else begin
        res = res >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] div_sat(longint n, longint d);
    logic   neg;
    longint un, ud, q;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = (2 * un + ud) / (2 * ud);
    if (neg) return (q > 32768) ? 16'h8000 : 16'(-q);
    return (q > 32767) ? 16'h7fff : 16'(q);
  endfunction

  function automatic logic [7:0] shade(longint base, longint gap, longint spd);
    longint t, q;
    t = 255 * (base - gap + spd);
    if (t <= 0) return 8'd0;
    q = (t + 6400) / 12800;
    return (q > 255) ? 8'd255 : 8'(q);
  endfunction

  // Project and shade one point under the current register copy
  function automatic pixel_t project_point(point_t p);
    pixel_t o;
    longint ca, sa, cp, sp, sc, gx, gy, gz, i, j, k, iy, ky, jyz, kyz, ms;
    longint dx, dy, dz, gap, spd, vx, vy, vz;
    ca = longint'($signed(shadow_reg[REG_COS_AZ]));
    sa = longint'($signed(shadow_reg[REG_SIN_AZ]));
    cp = longint'($signed(shadow_reg[REG_COS_PO]));
    sp = longint'($signed(shadow_reg[REG_SIN_PO]));
    sc = longint'(shadow_reg[REG_SCALE]);
    gx = longint'(shadow_reg[REG_GRID_X][8:0]);
    gy = longint'(shadow_reg[REG_GRID_Y][8:0]);
    gz = longint'(shadow_reg[REG_GRID_Z][8:0]);
    i = longint'(p.px) - (gx / 2) * 256;
    j = longint'(p.py) - (gy / 2) * 256;
    k = longint'(p.pz) - (gz / 2) * 256;
    vx = longint'($signed(p.vx));
    vy = longint'($signed(p.vy));
    vz = longint'($signed(p.vz));
    o = '0;
    o.last = p.last;
    iy = fshift14(i * ca - k * sa + 8192);
    ky = fshift14(i * sa + k * ca + 8192);
    jyz = fshift14(-j * cp - ky * sp + 8192);
    kyz = fshift14(-j * sp + ky * cp + 8192) + gz * 256;
    if (kyz == 0) begin
      o.skip = 1'b1;
      return o;
    end
    ms = gx;
    if (gy > ms) ms = gy;
    if (gz > ms) ms = gz;
    if (ms == 0) ms = 1;
    o.sx = div_sat(iy * sc * 64, kyz * ms);
    o.sy = div_sat(jyz * sc * 64, kyz * ms);
    dx = -((gx * 256 + 5) / 10) - i;
    dy = -((gy * 256 + 5) / 10) - j;
    dz = -((gz * 256 + 5) / 10) - k;
    gap = root(dx * dx + dy * dy + dz * dz);
    spd = root(vx * vx + vy * vy + vz * vz);
    o.r = shade(12800, gap, spd);
    o.g = shade(15360, gap, 0);
    o.b = shade(19200, gap, 0);
    return o;
  endfunction

  // Receiver: random stall, compare each transaction with the oldest entry
  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {screen_x_o, screen_y_o, red_o, green_o, blue_o, skipped_o, last_out_o};
        if (pixel_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = pixel_queue.pop_front();
          if (got.sx !== want.sx) begin
            $display("%0t: screen_x exp %h got %h", $time, want.sx, got.sx);
            errors++;
          end
          if (got.sy !== want.sy) begin
            $display("%0t: screen_y exp %h got %h", $time, want.sy, got.sy);
            errors++;
          end
          if (got.r !== want.r) begin
            $display("%0t: red exp %h got %h", $time, want.r, got.r);
            errors++;
          end
          if (got.g !== want.g) begin
            $display("%0t: green exp %h got %h", $time, want.g, got.g);
            errors++;
          end
          if (got.b !== want.b) begin
            $display("%0t: blue exp %h got %h", $time, want.b, got.b);
            errors++;
          end
          if (got.skip !== want.skip) begin
            $display("%0t: skipped exp %b got %b", $time, want.skip, got.skip);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last_out exp %b got %b", $time, want.last, got.last);
            errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  // Write one register while the core is idle; the caller drops valid
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < 8) shadow_reg[idx] = (idx >= REG_GRID_X) ? {7'd0, data[8:0]} : data;
  endtask

  // Send one point, optionally checking a typed-in result
  task automatic send_point(point_t p, logic fixed, pixel_t want);
    pixel_t pred;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pred = project_point(p);
    if (fixed && pred !== want) begin
      $display("%0t: table row exp %h model %h", $time, want, pred);
      errors++;
    end
    in_valid_i <= 1'b1;
    {pos_x_i, pos_y_i, pos_z_i, vel_x_i, vel_y_i, vel_z_i, last_point_i} <= p;
    do @(posedge clk_i); while (in_stall_o);
    pixel_queue.push_back(pred);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pixel_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  function automatic point_t rand_point();
    point_t p;
    p.px = 16'($urandom_range(4 * 256 * 64, 0));
    p.py = 16'($urandom_range(4 * 256 * 64, 0));
    p.pz = 16'($urandom_range(4 * 256 * 64, 0));
    p.vx = 16'($urandom);
    p.vy = 16'($urandom);
    p.vz = 16'($urandom);
    p.last = 1'($urandom);
    if ($urandom_range(3) == 0) p.px = 16'($urandom);
    if ($urandom_range(3) == 0) p.pz = 16'($urandom);
    if ($urandom_range(3) != 0) begin
      p.vx = 16'($signed(10'($urandom)));
      p.vy = 16'($signed(10'($urandom)));
    end
    return p;
  endfunction

  // Random register settings, extremes mixed in
  task automatic random_setting();
    logic [15:0] c, s;
    int sel;
    sel = $urandom_range(3);
    c = (sel == 0) ? 16'h4000 : (sel == 1) ? 16'hc000 : 16'($urandom_range(32767));
    s = (sel < 2) ? 16'd0 : 16'($urandom);
    write_reg(REG_COS_AZ, c);
    write_reg(REG_SIN_AZ, s);
    write_reg(REG_COS_PO, (sel == 3) ? 16'($urandom) : 16'h4000);
    write_reg(REG_SIN_PO, (sel == 3) ? 16'($urandom) : 16'd0);
    write_reg(REG_SCALE, (sel == 1) ? 16'hffff : 16'($urandom_range(2048)));
    write_reg(REG_GRID_X, (sel == 0) ? 16'd256 : 16'($urandom_range(256, 1)));
    write_reg(REG_GRID_Y, (sel == 1) ? 16'd1 : 16'($urandom));
    write_reg(REG_GRID_Z, (sel == 2) ? 16'd0 : 16'($urandom_range(256, 1)));
    cfg_valid_i <= 1'b0;
  endtask

  row_t directed [] = '{
    // Centre of the default grid: on axis
    '{1'b1, {16'h2000, 16'h2000, 16'h2000, 16'h0, 16'h0, 16'h0, 1'b0},
          {16'h0, 16'h0, 8'd198, 8'd249, 8'd255, 1'b0, 1'b0}},
    '{1'b0, {16'h0, 16'h0, 16'h0, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1}, '0},
    '{1'b0, {16'hffff, 16'hffff, 16'hffff, 16'h8000, 16'h8000, 16'h8000, 1'b0}, '0},
    '{1'b0, {16'hffff, 16'h0, 16'h2000, 16'h0100, 16'hff00, 16'h0, 1'b1}, '0},
    // Deep point straight behind the centre
    '{1'b0, {16'h2000, 16'h2000, 16'he000, 16'h1234, 16'h0, 16'h0, 1'b1}, '0},
    '{1'b0, {16'h0, 16'hffff, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 1'b0}, '0},
    // Near the camera point: bright
    '{1'b0, {16'h1999, 16'h1999, 16'h1999, 16'h3000, 16'h0, 16'h0, 1'b0}, '0}
  };

  initial begin
    point_t p;
    shadow_reg[REG_COS_AZ] = COS_RST;
    shadow_reg[REG_SIN_AZ] = SIN_RST;
    shadow_reg[REG_COS_PO] = COS_RST;
    shadow_reg[REG_SIN_PO] = SIN_RST;
    shadow_reg[REG_SCALE]  = SCALE_RST;
    shadow_reg[REG_GRID_X] = GRID_RST;
    shadow_reg[REG_GRID_Y] = GRID_RST;
    shadow_reg[REG_GRID_Z] = GRID_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table under reset settings
    foreach (directed[n]) send_point(directed[n].pt, directed[n].fixed, directed[n].px);
    drain();
    // Extreme settings: zero grids, half-turn azimuth, quarter-turn polar, max scale, unused index
    write_reg(REG_GRID_X, 16'd0);
    write_reg(REG_GRID_Y, 16'd0);
    write_reg(REG_GRID_Z, 16'd0);
    write_reg(REG_COS_AZ, 16'hc000);
    write_reg(REG_SIN_PO, 16'h4000);
    write_reg(REG_COS_PO, 16'h0);
    write_reg(REG_SCALE, 16'hffff);
    write_reg(4'd9, 16'h1234);
    cfg_valid_i <= 1'b0;
    foreach (directed[n]) send_point(directed[n].pt, 1'b0, '0);
    drain();

    // Random phases with changing settings and idling profiles
    for (int ph = 0; ph < 7; ph++) begin
      random_setting();
      if (ph == 2) begin
        send_idle = 50;
        recv_idle = 26;
      end else if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int n = 0; n < 100; n++) begin
        p = rand_point();
        send_point(p, 1'b0, '0);
        // Hold off until the pipeline is empty once per phase
        if (n == 50) begin
          in_valid_i <= 1'b0;
          while (pixel_queue.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
